### sv/csgsid_pkg.sv
// Shared types and constants for the charset glyph-to-SID lookup block.
package csgsid_pkg;

    // Opcodes of an input transaction.
    localparam logic [1:0] OP_LOAD_ARRAY = 2'd0;
    localparam logic [1:0] OP_LOAD_RANGE = 2'd1;
    localparam logic [1:0] OP_LOOKUP     = 2'd2;

    // Charset formats.
    localparam logic [7:0] FMT_ARRAY   = 8'd0;
    localparam logic [7:0] FMT_RANGES1 = 8'd1;
    localparam logic [7:0] FMT_RANGES2 = 8'd2;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 9;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_COUNT = 2'd1;
    localparam logic [7:0] FORMAT_RESET      = 8'd255;
    localparam logic [8:0] RANGE_COUNT_RESET = 9'd0;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] entry_index;
        logic [15:0] entry_sid;
        logic [15:0] entry_left;
        logic [15:0] glyph_id;
    } t_in_item;

    typedef struct packed {
        logic [15:0] sid;
        logic        hit;
    } t_out_item;

    // How a lookup is resolved, decided when it is accepted.
    typedef enum logic [1:0] {
        PATH_MISS   = 2'd0,
        PATH_ARRAY  = 2'd1,
        PATH_RANGES = 2'd2
    } t_path;

    typedef struct packed {
        logic accept;
        logic accept_lookup;
        logic take_array;
        logic walk_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_path path;
        logic  walk_done;
        logic  out_free;
    } t_status;

endpackage

### sv/csgsid_ctrl.sv
// Controller state machine that sequences loads, lookups and result hand-off.
module csgsid_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_opcode,
    input  csgsid_pkg::t_status i_status,
    output logic                o_in_stall,
    output csgsid_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ARRAY,
        S_WALK,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_lookup;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_lookup   = w_accept && (i_opcode == csgsid_pkg::OP_LOOKUP);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd               = '0;
        o_cmd.accept        = w_accept;
        o_cmd.accept_lookup = w_lookup;
        o_cmd.take_array    = (r_state == S_ARRAY);
        o_cmd.walk_step     = (r_state == S_WALK);
        o_cmd.load_out      = (r_state == S_HOLD) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_lookup) begin
                    case (i_status.path)
                        csgsid_pkg::PATH_ARRAY:  n_state = S_ARRAY;
                        csgsid_pkg::PATH_RANGES: n_state = S_WALK;
                        default:                 n_state = S_HOLD;
                    endcase
                end
            end
            S_ARRAY: n_state = S_HOLD;
            S_WALK: begin
                if (i_status.walk_done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_lookup_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lookup) |=> (r_state != S_IDLE))
        else $error("lookup accepted but controller stayed idle");

    a_walk_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_status.walk_done) |=> (r_state == S_HOLD))
        else $error("finished range walk did not move to hold");

    a_hold_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && !i_status.out_free) |=> (r_state == S_HOLD))
        else $error("result left hold while output register was busy");
`endif

endmodule

### sv/csgsid_dp.sv
// Datapath: configuration, SID array and range memories, range walker, output register.
module csgsid_dp #(
    parameter int unsigned ARRAY_DEPTH = 4096,
    parameter int unsigned MAX_RANGES  = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [csgsid_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [csgsid_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  csgsid_pkg::t_in_item                i_in_data,
    input  logic                                i_out_stall,
    input  csgsid_pkg::t_cmd                    i_cmd,
    output csgsid_pkg::t_status                 o_status,
    output logic                                o_out_valid,
    output csgsid_pkg::t_out_item               o_out_data
);

    localparam int unsigned AW = $clog2(ARRAY_DEPTH);
    localparam int unsigned RW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int unsigned CW = $clog2(MAX_RANGES + 1);

    typedef struct packed {
        logic [15:0] first_sid;
        logic [15:0] left;
    } t_range;

    logic [15:0]           r_arr_mem [ARRAY_DEPTH];
    t_range                r_rng_mem [MAX_RANGES];
    logic [15:0]           r_arr_q;
    t_range                r_rng_q;

    logic [7:0]            r_format;
    logic [8:0]            r_range_count;
    logic [15:0]           r_glyph;
    logic [16:0]           r_start;
    logic [CW-1:0]         r_remain;
    logic [CW-1:0]         r_issue;
    csgsid_pkg::t_out_item r_res;
    logic                  r_out_valid;
    csgsid_pkg::t_out_item r_out_data;

    logic [31:0]           w_slot;
    logic [31:0]           w_idx;
    logic [31:0]           w_n;
    logic                  w_arr_we;
    logic                  w_rng_we;
    csgsid_pkg::t_path     w_path;
    logic                  w_exhausted;
    logic                  w_past;
    logic [15:0]           w_diff;
    logic                  w_in_range;
    logic                  w_walk_done;
    logic                  w_issue_ok;

    assign w_slot   = 32'(i_in_data.entry_index);
    assign w_idx    = 32'(i_in_data.glyph_id) - 32'd1;
    assign w_n      = (32'(r_range_count) > 32'(MAX_RANGES)) ? 32'(MAX_RANGES)
                                                             : 32'(r_range_count);
    assign w_arr_we = i_cmd.accept && (i_in_data.opcode == csgsid_pkg::OP_LOAD_ARRAY)
                      && (w_slot < 32'(ARRAY_DEPTH));
    assign w_rng_we = i_cmd.accept && (i_in_data.opcode == csgsid_pkg::OP_LOAD_RANGE)
                      && (w_slot < 32'(MAX_RANGES));

    always_comb begin
        w_path = csgsid_pkg::PATH_MISS;
        if (i_in_data.glyph_id != 16'd0) begin
            if (r_format == csgsid_pkg::FMT_ARRAY) begin
                if (w_idx < 32'(ARRAY_DEPTH)) begin
                    w_path = csgsid_pkg::PATH_ARRAY;
                end
            end else if (r_format inside {csgsid_pkg::FMT_RANGES1, csgsid_pkg::FMT_RANGES2})
            begin
                w_path = csgsid_pkg::PATH_RANGES;
            end
        end
    end

    // One range is checked per cycle; the running start never passes the glyph
    // by more than one range, so 17 bits hold it.
    assign w_exhausted = (r_remain == '0);
    assign w_past      = (r_start > {1'b0, r_glyph});
    assign w_diff      = r_glyph - r_start[15:0];
    assign w_in_range  = !w_exhausted && !w_past && (w_diff <= r_rng_q.left);
    assign w_walk_done = w_exhausted || w_past || w_in_range;
    assign w_issue_ok  = (32'(r_issue) < 32'(MAX_RANGES));

    always_comb begin
        o_status           = '0;
        o_status.path      = w_path;
        o_status.walk_done = w_walk_done;
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (w_arr_we) begin
            r_arr_mem[w_slot[AW-1:0]] <= i_in_data.entry_sid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_lookup) begin
            r_arr_q <= r_arr_mem[w_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rng_we) begin
            r_rng_mem[w_slot[RW-1:0]] <= '{first_sid: i_in_data.entry_sid,
                                           left:      i_in_data.entry_left};
        end
    end

    // The next range is fetched while the current one is checked.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_lookup) begin
            r_rng_q <= r_rng_mem[RW'(0)];
        end else if (i_cmd.walk_step && !w_walk_done && w_issue_ok) begin
            r_rng_q <= r_rng_mem[r_issue[RW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format      <= csgsid_pkg::FORMAT_RESET;
            r_range_count <= csgsid_pkg::RANGE_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                csgsid_pkg::CFG_FORMAT:      r_format      <= i_cfg_data[7:0];
                csgsid_pkg::CFG_RANGE_COUNT: r_range_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_lookup) begin
            r_glyph  <= i_in_data.glyph_id;
            r_start  <= 17'd1;
            r_remain <= w_n[CW-1:0];
            r_issue  <= CW'(1);
        end else if (i_cmd.walk_step && !w_walk_done) begin
            r_start  <= r_start + 17'(r_rng_q.left) + 17'd1;
            r_remain <= r_remain - CW'(1);
            r_issue  <= r_issue + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_lookup) begin
            r_res <= '0;
        end else if (i_cmd.take_array) begin
            r_res <= '{sid: r_arr_q, hit: 1'b1};
        end else if (i_cmd.walk_step && w_walk_done) begin
            if (w_in_range) begin
                r_res <= '{sid: r_rng_q.first_sid + w_diff, hit: 1'b1};
            end else begin
                r_res <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    a_out_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_cmd.load_out))
        else $error("output valid rose without a result hand-off");

    a_remain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |-> (32'(r_remain) <= 32'(MAX_RANGES)))
        else $error("range walk counter exceeds the range store depth");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hit) |-> (o_out_data.sid == 16'd0))
        else $error("missed lookup carries a nonzero SID");
`endif

endmodule

### sv/charset_glyph_to_sid_lookup.sv
// Top level of the charset glyph-to-SID lookup block.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+-----------------------
//  input    | in        | i_in_valid / o_in_stall       | i_in_data  (t_in_item)
//  result   | out       | o_out_valid / i_out_stall     | o_out_data (t_out_item)
//  config   | in        | i_cfg_we, i_cfg_index         | i_cfg_data
//
// Loads leave the controller idle, so loads can arrive every cycle while no lookup is pending.
// A missing lookup goes straight to the hold state, which loads the output register; the
// direct-array format passes the array state first, and a range walk checks one range per
// step from the single read port, plus one step when the glyph lies past the last range.
// The next transaction is accepted the cycle after the result enters the output register;
// while that register is full and stalled, a finished result waits inside the block.
// Reset is synchronous and clears control and configuration; the memories are not cleared.
module charset_glyph_to_sid_lookup #(
    parameter int unsigned ARRAY_DEPTH = 4096,
    parameter int unsigned MAX_RANGES  = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [csgsid_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [csgsid_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  csgsid_pkg::t_in_item               i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output csgsid_pkg::t_out_item              o_out_data
);

    csgsid_pkg::t_cmd    w_cmd;
    csgsid_pkg::t_status w_status;

    csgsid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    csgsid_dp #(
        .ARRAY_DEPTH (ARRAY_DEPTH),
        .MAX_RANGES  (MAX_RANGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
